FILE: rtl/core/adf_pkg.sv
// Shared types, character codes and fraction weight table for the ASCII
// decimal to fixed-point converter. No dependencies.
package adf_pkg;

	localparam int INT_BITS_DEF    = 31;
	localparam int FRAC_DIGITS_DEF = 9;

	localparam logic [7:0] CH_DIGIT_LO = 8'd47;
	localparam logic [7:0] CH_DIGIT_HI = 8'd58;
	localparam logic [7:0] CH_ZERO     = 8'd48;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_POINT    = 8'h2E;
	localparam logic [5:0] COUNT_MAX   = 6'd63;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_INT  = 3'b010,
		PH_FRAC = 3'b100
	} adf_phase_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [5:0]         chars_used;
		logic               overflow;
	} adf_result_t;

	function automatic logic [31:0] frac_weight(input logic [3:0] idx);
		logic [31:0] w;
		unique case (idx)
			4'd0:    w = 32'd429496730;
			4'd1:    w = 32'd42949673;
			4'd2:    w = 32'd4294967;
			4'd3:    w = 32'd429497;
			4'd4:    w = 32'd42950;
			4'd5:    w = 32'd4295;
			4'd6:    w = 32'd429;
			4'd7:    w = 32'd43;
			4'd8:    w = 32'd4;
			default: w = 32'd0;
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/adf_step.sv
// Per-character number state and its registered update; emits the result
// when a terminating character arrives. Depends on adf_pkg.
module adf_step import adf_pkg::*; #(
	parameter int INT_BITS    = INT_BITS_DEF,
	parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [7:0]  char_s1,
	input  logic        start_s1,
	output logic        emit,
	output adf_result_t res
);

	localparam int          WideW   = INT_BITS + 4;
	localparam logic [3:0]  FracLim = 4'(FRAC_DIGITS);

	adf_phase_t          phase_q, phase_n, w_phase;
	logic                neg_q, neg_n, w_neg;
	logic [INT_BITS-1:0] int_q, int_n, w_int;
	logic [31:0]         frac_q, frac_n, w_frac;
	logic [3:0]          pos_q, pos_n, w_pos;
	logic [5:0]          cnt_q, cnt_n, w_cnt, cnt_inc;
	logic                sat_q, sat_n, w_sat, sat_inc;
	logic                active, is_digit;
	logic [3:0]          d;
	logic [WideW-1:0]    wide_int, int_next;
	logic [35:0]         frac_prod;
	logic [63:0]         mag;

	always_comb begin
		active   = start_s1 || (phase_q == PH_INT) || (phase_q == PH_FRAC);
		w_phase  = start_s1 ? PH_INT : phase_q;
		w_neg    = start_s1 ? 1'b0 : neg_q;
		w_int    = start_s1 ? '0 : int_q;
		w_frac   = start_s1 ? '0 : frac_q;
		w_pos    = start_s1 ? '0 : pos_q;
		w_cnt    = start_s1 ? '0 : cnt_q;
		w_sat    = start_s1 ? 1'b0 : sat_q;
		is_digit = (char_s1 > CH_DIGIT_LO) && (char_s1 < CH_DIGIT_HI);
		d        = 4'(char_s1 - CH_ZERO);

		cnt_inc  = (w_cnt == COUNT_MAX) ? COUNT_MAX : w_cnt + 6'd1;
		sat_inc  = w_sat || (w_cnt == COUNT_MAX);

		wide_int  = {4'b0, w_int};
		int_next  = (wide_int << 3) + (wide_int << 1) + WideW'(d);
		frac_prod = {32'b0, d} * {4'b0, frac_weight(w_pos)};
		mag       = {{(32 - INT_BITS){1'b0}}, w_int, w_frac};

		res.value      = w_neg ? 64'sd0 - signed'(mag) : signed'(mag);
		res.chars_used = w_cnt;
		res.overflow   = w_sat;

		phase_n = w_phase;
		neg_n   = w_neg;
		int_n   = w_int;
		frac_n  = w_frac;
		pos_n   = w_pos;
		cnt_n   = w_cnt;
		sat_n   = w_sat;
		emit    = 1'b0;

		priority if (!active) begin
			phase_n = PH_IDLE;
		end else if (start_s1 && char_s1 == CH_MINUS) begin
			neg_n = 1'b1;
			cnt_n = cnt_inc;
			sat_n = sat_inc;
		end else if (is_digit) begin
			cnt_n = cnt_inc;
			sat_n = sat_inc;
			if (w_phase == PH_INT) begin
				if (int_next[WideW-1:INT_BITS] != '0) begin
					int_n = '1;
					sat_n = 1'b1;
				end else begin
					int_n = int_next[INT_BITS-1:0];
				end
			end else if (w_pos < FracLim) begin
				frac_n = w_frac + frac_prod[31:0];
				pos_n  = w_pos + 4'd1;
			end
		end else if (char_s1 == CH_POINT && w_phase == PH_INT) begin
			phase_n = PH_FRAC;
			cnt_n   = cnt_inc;
			sat_n   = sat_inc;
		end else begin
			phase_n = PH_IDLE;
			emit    = 1'b1;
		end

		if (!step_en)
			emit = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			sat_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_n;
			neg_q   <= neg_n;
			int_q   <= int_n;
			frac_q  <= frac_n;
			pos_q   <= pos_n;
			cnt_q   <= cnt_n;
			sat_q   <= sat_n;
		end
	end

endmodule

FILE: rtl/core/ascii_decimal_to_fixed.sv
// Top level: ASCII decimal text to signed Q31.32, input register, step
// logic (adf_step) and result register. Depends on adf_pkg.
//
//  channel | handshake            | beat payload
//  in      | in_valid / in_ready  | char_in, start_req
//  out     | out_valid / out_ready| value, chars_used, overflow
//
// One character per cycle sustained while no result is held; a result is valid
// once the terminating character's beat has been taken (input register, then the
// per-character update that writes the result register).
// Reset clears the number state and both valid flags.
// A held result stalls the update for every character; in_ready drops
// once the input register is full and the update is stalled.
module ascii_decimal_to_fixed import adf_pkg::*; #(
	parameter int INT_BITS    = INT_BITS_DEF,
	parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_in,
	input  logic               start_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] value,
	output logic [5:0]         chars_used,
	output logic               overflow
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        start_s1;
	logic        step_en;
	logic        emit;
	adf_result_t res;
	logic        out_valid_q;
	adf_result_t out_q;

	assign step_en  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= char_in;
			start_s1 <= start_req;
		end
	end

	adf_step #(
		.INT_BITS    (INT_BITS),
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.char_s1  (char_s1),
		.start_s1 (start_s1),
		.emit     (emit),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign value      = out_q.value;
	assign chars_used = out_q.chars_used;
	assign overflow   = out_q.overflow;

endmodule

FILE: rtl/core/adf_checker.sv
// Port-level checks for ascii_decimal_to_fixed, attached by bind.
// Depends on the top level's ports only.
module adf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [7:0]         char_in,
	input logic               start_req,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [63:0] value,
	input logic [5:0]         chars_used,
	input logic               overflow
);

	// hold a waiting character beat
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(char_in) && $stable(start_req))
		else $error("waiting character beat changed");

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value)
			&& $stable(chars_used) && $stable(overflow))
		else $error("stalled result beat changed");

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chars_used == 6'd0 |-> value == 64'sd0 && !overflow)
		else $error("empty number gave nonzero result");

	a_overflow_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> chars_used >= 6'd3)
		else $error("overflow on too short a number");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind ascii_decimal_to_fixed adf_checker u_adf_checker (.*);

FILE: tb/ascii_decimal_to_fixed_test.sv
// Self-checking testbench for ascii_decimal_to_fixed: directed table, then random numbers,
// with random idling on both channels, scored against table results or a local parser model.
// Depends on adf_pkg and the ascii_decimal_to_fixed RTL.
module ascii_decimal_to_fixed_test;
	import adf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  ch;
		logic        st;
		logic        typed;
		adf_result_t res;
	} dir_row_t;

	localparam int          DIR_ROWS  = 24;
	localparam int          RAND_BEATS = 850;
	localparam logic [63:0] INT_LIMIT = 64'h0000_0000_7FFF_FFFF;
	localparam logic [31:0] FRAC_STEP [9] = '{
		32'd429496730, 32'd42949673, 32'd4294967, 32'd429497, 32'd42950,
		32'd4295, 32'd429, 32'd43, 32'd4
	};

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{8'hFF, 1'b1, 1'b1, '{64'sd0, 6'd0, 1'b0}},
		'{CH_MINUS, 1'b1, 1'b0, '0},
		'{CH_POINT, 1'b0, 1'b0, '0},
		'{8'h2F, 1'b0, 1'b1, '{64'sd0, 6'd2, 1'b0}},
		'{8'h33, 1'b0, 1'b0, '0},
		'{CH_POINT, 1'b1, 1'b0, '0},
		'{8'h35, 1'b0, 1'b0, '0},
		'{CH_POINT, 1'b0, 1'b1, '{64'sd2147483650, 6'd2, 1'b0}},
		'{8'h39, 1'b1, 1'b0, '0},
		'{CH_MINUS, 1'b1, 1'b0, '0},
		'{CH_MINUS, 1'b0, 1'b1, '{64'sd0, 6'd1, 1'b0}},
		'{8'h39, 1'b1, 1'b0, '0},
		'{8'h39, 1'b0, 1'b0, '0},
		'{8'h39, 1'b0, 1'b0, '0},
		'{8'h39, 1'b0, 1'b0, '0},
		'{8'h39, 1'b0, 1'b0, '0},
		'{8'h39, 1'b0, 1'b0, '0},
		'{8'h39, 1'b0, 1'b0, '0},
		'{8'h39, 1'b0, 1'b0, '0},
		'{8'h39, 1'b0, 1'b0, '0},
		'{8'h39, 1'b0, 1'b0, '0},
		'{8'h3A, 1'b0, 1'b1, '{64'sh7FFF_FFFF_0000_0000, 6'd10, 1'b1}},
		'{8'h30, 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{64'sd0, 6'd1, 1'b0}}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         char_in;
	logic               start_req;
	logic               out_valid;
	logic               out_ready;
	logic signed [63:0] value;
	logic [5:0]         chars_used;
	logic               overflow;

	adf_result_t results_due [$];
	int          errors;
	bit          calm;

	adf_phase_t  p_phase;
	logic        p_neg;
	logic [30:0] p_int;
	logic [31:0] p_frac;
	logic [3:0]  p_fpos;
	logic [5:0]  p_cnt;
	logic        p_sat;

	ascii_decimal_to_fixed u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.start_req  (start_req),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.chars_used (chars_used),
		.overflow   (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic bit fits_number(input logic [7:0] ch);
		return (ch > CH_DIGIT_LO && ch < CH_DIGIT_HI) || ch == CH_POINT || ch == CH_MINUS;
	endfunction

	task automatic clear_number();
		p_neg  = 1'b0;
		p_int  = '0;
		p_frac = '0;
		p_fpos = '0;
		p_cnt  = '0;
		p_sat  = 1'b0;
	endtask

	task automatic bump_count();
		if (p_cnt == COUNT_MAX) begin
			p_sat = 1'b1;
		end else begin
			p_cnt = p_cnt + 6'd1;
		end
	endtask

	// Advance the parser by one accepted character; done flags a finished number.
	task automatic parse_char(input logic [7:0] ch, input logic st, output bit done,
			output adf_result_t r);
		logic [63:0] grown;
		logic [63:0] mag;
		done = 1'b0;
		r = '0;
		if (st) begin
			clear_number();
			p_phase = PH_INT;
			if (ch == CH_MINUS) begin
				p_neg = 1'b1;
				bump_count();
				return;
			end
		end else if (p_phase != PH_INT && p_phase != PH_FRAC) begin
			p_phase = PH_IDLE;
			return;
		end
		if (ch > CH_DIGIT_LO && ch < CH_DIGIT_HI) begin
			if (p_phase == PH_INT) begin
				grown = 64'(p_int) * 64'd10 + 64'(ch - CH_ZERO);
				if (grown > INT_LIMIT) begin
					grown = INT_LIMIT;
					p_sat = 1'b1;
				end
				p_int = grown[30:0];
			end else if (p_fpos < 4'd9) begin
				p_frac = p_frac + 32'(ch - CH_ZERO) * FRAC_STEP[p_fpos];
				p_fpos = p_fpos + 4'd1;
			end
			bump_count();
			return;
		end
		if (ch == CH_POINT && p_phase == PH_INT) begin
			p_phase = PH_FRAC;
			bump_count();
			return;
		end
		mag = {1'b0, p_int, p_frac};
		r.value = p_neg ? -mag : mag;
		r.chars_used = p_cnt;
		r.overflow = p_sat;
		p_phase = PH_IDLE;
		done = 1'b1;
	endtask

	task automatic send_char(input logic [7:0] ch, input logic st, input bit typed,
			input adf_result_t want);
		adf_result_t got;
		bit          done;
		int unsigned gap;
		char_in   <= ch;
		start_req <= st;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!in_ready);
		parse_char(ch, st, done, got);
		if (typed) begin
			results_due.push_back(want);
		end else if (done) begin
			results_due.push_back(got);
		end
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int unsigned pick_run();
		if ($urandom_range(0, 99) < 3) begin
			return $urandom_range(55, 70);
		end
		return $urandom_range(0, 12);
	endfunction

	// Build one number with random content; a few start bad, stop short or end oddly.
	task automatic send_number(output int unsigned beats);
		logic [7:0]  text [$];
		logic [7:0]  b;
		int unsigned n;
		int unsigned r;
		if ($urandom_range(0, 99) < 5) begin
			do b = 8'($urandom_range(0, 255)); while (fits_number(b));
			text.push_back(b);
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				text.push_back(CH_MINUS);
			end
			n = pick_run();
			repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			if ($urandom_range(0, 2) != 0) begin
				text.push_back(CH_POINT);
				n = pick_run();
				repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			r = $urandom_range(0, 99);
			if (r < 10) begin
				n = $urandom_range(0, text.size());
				while (text.size() > n) void'(text.pop_back());
			end else if (r < 55) begin
				do b = 8'($urandom_range(0, 255)); while (fits_number(b));
				text.push_back(b);
			end else if (r < 70) begin
				text.push_back(CH_POINT);
			end else if (r < 85) begin
				text.push_back(CH_MINUS);
			end else begin
				text.push_back(8'($urandom_range(0, 255)));
			end
		end
		beats = text.size();
		foreach (text[i]) begin
			send_char(text[i], i == 0, 1'b0, '0);
		end
	endtask

	initial begin
		int unsigned hold;
		adf_result_t want;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: value %0d chars_used %0d overflow %0b",
						value, chars_used, overflow);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, value);
						errors++;
					end
					if (chars_used !== want.chars_used) begin
						$error("chars_used: expected %0d, got %0d", want.chars_used, chars_used);
						errors++;
					end
					if (overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b", want.overflow, overflow);
						errors++;
					end
				end
			end
			if (hold != 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	initial begin
		int unsigned sent;
		int unsigned beats;
		int unsigned waited;
		bit          paused;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		char_in   = '0;
		start_req = 1'b0;
		errors    = 0;
		calm      = 1'b0;
		sent      = 0;
		paused    = 1'b0;
		p_phase   = PH_IDLE;
		clear_number();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			send_char(DIRECTED[i].ch, DIRECTED[i].st, DIRECTED[i].typed, DIRECTED[i].res);
		end

		while (sent < RAND_BEATS) begin
			if ($urandom_range(0, 39) == 0) begin
				calm = !calm;
			end
			if ($urandom_range(0, 99) < 8) begin
				repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
			end
			send_number(beats);
			sent += beats;
			if (!paused && sent >= RAND_BEATS / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				while (results_due.size() != 0) @(posedge clk);
			end
		end

		// Terminate any open number, then drain.
		send_char(8'h20, 1'b0, 1'b0, '0);
		in_valid <= 1'b0;
		waited = 0;
		while (results_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d results never arrived", results_due.size());
			errors++;
		end
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
